>>> rtl/aab_pkg.sv
package aab_pkg;

  // Bit positions inside one two-bit age mark.
  localparam logic [1:0] MARK_CLEAR = 2'b00;
  localparam logic [1:0] MARK_NEWER = 2'b01;
  localparam logic [1:0] MARK_OLDER = 2'b10;
  localparam logic [1:0] MARK_BOTH  = 2'b11;

  // Request opcodes and result kinds.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_SWEEP  = 1'b1;

  // Status and memory enables from the sweep sequencer.
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_en;
    logic done;
  } aab_seq_ctl_t;

  // One aging step: a set newer bit is dropped first, else the older bit.
  function automatic logic [1:0] age_mark(input logic [1:0] m);
    logic [1:0] r;
    r = m;
    if ((m & MARK_NEWER) != MARK_CLEAR) begin
      r = m & ~MARK_NEWER;
    end else if ((m & MARK_OLDER) != MARK_CLEAR) begin
      r = m & ~MARK_OLDER;
    end
    return r;
  endfunction

endpackage

>>> rtl/aab_mark_ram.sv
module aab_mark_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [1:0]           rd_data_r,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [1:0]           wr_data
);

  localparam longint unsigned DEPTH = 64'd1 << ADDR_BITS;

  logic [1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/aab_seq.sv
module aab_seq #(
  parameter int ADDR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  done_ack,
  input  logic [1:0]            rd_data,
  output aab_pkg::aab_seq_ctl_t ctl,
  output logic [ADDR_BITS-1:0]  rd_addr,
  output logic [ADDR_BITS-1:0]  wr_addr,
  output logic [1:0]            wr_data
);
  import aab_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } seq_state_t;

  seq_state_t           state_r;
  logic [ADDR_BITS-1:0] cnt_r;
  logic                 rd_live_r;
  logic                 wb_valid_r;
  logic [ADDR_BITS-1:0] wb_idx_r;

  // Sequencer state, address counter and write-back slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      rd_live_r  <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_r   <= ST_SWEEP;
            cnt_r     <= '0;
            rd_live_r <= 1'b1;
          end
        end
        ST_SWEEP: begin
          wb_valid_r <= rd_live_r;
          if (rd_live_r) begin
            wb_idx_r <= cnt_r;
            cnt_r    <= cnt_r + 1'b1;
            if (cnt_r == '1) begin
              rd_live_r <= 1'b0;
            end
          end
          // The last write-back happens once reading has stopped.
          if (wb_valid_r && !rd_live_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_ack) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Memory requests: zero fill while clearing, read-age-write while sweeping.
  always_comb begin
    ctl.busy  = (state_r != ST_IDLE);
    ctl.done  = (state_r == ST_DONE);
    ctl.rd_en = (state_r == ST_SWEEP) && rd_live_r;
    ctl.wr_en = (state_r == ST_CLEAR) || ((state_r == ST_SWEEP) && wb_valid_r);
    rd_addr   = cnt_r;
    if (state_r == ST_CLEAR) begin
      wr_addr = cnt_r;
      wr_data = MARK_CLEAR;
    end else begin
      wr_addr = wb_idx_r;
      wr_data = age_mark(rd_data);
    end
  end

endmodule

>>> rtl/aging_auth_bitmap.sv
// Per-key two-bit age mark table held in one 2^KEY_BITS x 2 synchronous RAM.
// An update request (cmd 0) reads the mark of the low KEY_BITS bits of key,
// answers with the older bit as authenticated, and writes both bits set when
// that bit was set or forced is 1. Updates stream at one per cycle while no
// sweep runs and the output is not stalled: the RAM read happens at
// acceptance and the write-back when the request leaves the update stage,
// with a forwarding path when the next request hits the key just written;
// the answer is loaded into the output register as the request leaves the
// update stage. An age sweep request (cmd 1) stops intake and walks the RAM
// one entry per cycle through its single read and single write port,
// finishing with one result of kind 1. After reset the block zero-fills the
// RAM, one entry per cycle, and accepts no request until the fill is done.
module aging_auth_bitmap #(
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_key,
  input  logic        in_forced,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_authenticated,
  output logic        out_result_kind
);
  import aab_pkg::*;

  aab_seq_ctl_t        seq_ctl;
  logic [KEY_BITS-1:0] seq_rd_addr;
  logic [KEY_BITS-1:0] seq_wr_addr;
  logic [1:0]          seq_wr_data;

  logic                s1_valid_r;
  logic [KEY_BITS-1:0] s1_idx_r;
  logic                s1_forced_r;
  logic                s1_fwd_r;

  logic                out_valid_r;
  logic                out_auth_r;
  logic                out_kind_r;

  logic [KEY_BITS-1:0] in_idx;
  logic                out_free;
  logic                s1_adv;
  logic                in_ready;
  logic                in_acc;
  logic                upd_rd_en;
  logic                upd_wr_en;
  logic [1:0]          mark_cur;
  logic                auth;
  logic                done_ack;

  logic                mem_rd_en;
  logic [KEY_BITS-1:0] mem_rd_addr;
  logic                mem_wr_en;
  logic [KEY_BITS-1:0] mem_wr_addr;
  logic [1:0]          mem_wr_data;
  logic [1:0]          mem_rd_data;

  // Handshake and update datapath.
  always_comb begin
    in_idx    = KEY_BITS'(in_key);
    out_free  = !out_valid_r || !out_stall;
    s1_adv    = s1_valid_r && out_free;
    in_ready  = !seq_ctl.busy && (!s1_valid_r || s1_adv);
    in_acc    = in_valid && in_ready;
    upd_rd_en = in_acc && (in_cmd == CMD_UPDATE);
    mark_cur  = s1_fwd_r ? MARK_BOTH : mem_rd_data;
    auth      = ((mark_cur & MARK_OLDER) != MARK_CLEAR);
    upd_wr_en = s1_adv && (auth || s1_forced_r);
    done_ack  = seq_ctl.done && out_free && !s1_adv;
  end

  assign in_stall = !in_ready;

  // The sequencer owns the RAM while it clears or sweeps.
  always_comb begin
    mem_rd_en   = seq_ctl.rd_en || upd_rd_en;
    mem_rd_addr = seq_ctl.rd_en ? seq_rd_addr : in_idx;
    mem_wr_en   = seq_ctl.wr_en || upd_wr_en;
    mem_wr_addr = seq_ctl.wr_en ? seq_wr_addr : s1_idx_r;
    mem_wr_data = seq_ctl.wr_en ? seq_wr_data : MARK_BOTH;
  end

  // Update stage: holds the request while its RAM read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (upd_rd_en) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // A write to the same key at the read edge is not seen by the RAM read.
  always_ff @(posedge clk) begin
    if (upd_rd_en) begin
      s1_idx_r    <= in_idx;
      s1_forced_r <= in_forced;
      s1_fwd_r    <= upd_wr_en && (s1_idx_r == in_idx);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv || done_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_auth_r <= auth;
      out_kind_r <= KIND_UPDATE;
    end else if (done_ack) begin
      out_auth_r <= 1'b0;
      out_kind_r <= KIND_SWEEP;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_authenticated = out_auth_r;
  assign out_result_kind   = out_kind_r;

  aab_seq #(
    .ADDR_BITS(KEY_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && (in_cmd == CMD_SWEEP)),
    .done_ack(done_ack),
    .rd_data (mem_rd_data),
    .ctl     (seq_ctl),
    .rd_addr (seq_rd_addr),
    .wr_addr (seq_wr_addr),
    .wr_data (seq_wr_data)
  );

  aab_mark_ram #(
    .ADDR_BITS(KEY_BITS)
  ) u_ram (
    .clk      (clk),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_data_r(mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data)
  );

endmodule
